@@ rtl/lqpa_pkg.sv @@
// Shared types and constants for the link quality path advisor.
package lqpa_pkg;

    // Default structure sizes.
    localparam int LQPA_RING_DEPTH = 20;
    localparam int LQPA_RUN_LIMIT  = 3;
    localparam int LQPA_PATH_COUNT = 2;

    // Highest loss percentage that is still a valid report.
    localparam logic [6:0] LOSS_MAX = 7'd100;

    // Register reset values.
    localparam logic [1:0]  RST_PATH_MASK  = 2'd0;
    localparam logic [15:0] RST_DELAY_BAD  = 16'd80;
    localparam logic [15:0] RST_DELAY_GOOD = 16'd60;
    localparam logic [15:0] RST_REL_BAD    = 16'd20;
    localparam logic [15:0] RST_REL_GOOD   = 16'd10;
    localparam logic [15:0] RST_RISE       = 16'd5;
    localparam logic [6:0]  RST_LOSS_BAD   = 7'd6;
    localparam logic [6:0]  RST_LOSS_GOOD  = 7'd4;

    // Run counters saturate at plus and minus this value.
    localparam logic signed [4:0] RUN_SAT     = 5'sd15;
    localparam logic signed [4:0] RUN_SAT_NEG = -5'sd15;

    typedef enum logic [3:0] {
        CFG_PATH_MASK  = 4'd0,
        CFG_DELAY_BAD  = 4'd1,
        CFG_DELAY_GOOD = 4'd2,
        CFG_REL_BAD    = 4'd3,
        CFG_REL_GOOD   = 4'd4,
        CFG_RISE       = 4'd5,
        CFG_LOSS_BAD   = 4'd6,
        CFG_LOSS_GOOD  = 4'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        Q_BAD   = 2'd0,
        Q_FLUCT = 2'd1,
        Q_GOOD  = 2'd2
    } t_quality;

    typedef enum logic [1:0] {
        ADV_PATH_ONE = 2'd0,
        ADV_PATH_TWO = 2'd1,
        ADV_BOTH     = 2'd2
    } t_advice;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_MIN,
        S_MIN_END,
        S_GRAD_A,
        S_GRAD_B,
        S_GRAD_C,
        S_CALC,
        S_EVAL,
        S_DONE
    } t_state;

    typedef logic signed [4:0] t_run;

    typedef struct packed {
        logic        probe_path;
        logic [15:0] rtt_ms;
        logic [6:0]  loss_percent;
    } t_probe;

    typedef struct packed {
        logic     ignored;
        t_quality quality;
        logic     advice_valid;
        t_advice  advice;
    } t_result;

    typedef struct packed {
        logic [1:0]  path_use_mask;
        logic [15:0] delay_bad_limit;
        logic [15:0] delay_good_limit;
        logic [15:0] relative_bad_limit;
        logic [15:0] relative_good_limit;
        logic [15:0] gradient_rise_limit;
        logic [6:0]  loss_bad_limit;
        logic [6:0]  loss_good_limit;
    } t_cfg;

    // Measurements handed to the grading unit for one report.
    typedef struct packed {
        logic [15:0]        rtt;
        logic [6:0]         loss;
        logic signed [16:0] rel;
        logic signed [16:0] grad;
        logic signed [16:0] last_grad;
    } t_grade_req;

endpackage

@@ rtl/lqpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lqpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lqpa_grade.sv @@
// Per-path run counters with hysteresis and the quality grading logic.
module lqpa_grade import lqpa_pkg::*; #(
    parameter int PATH_COUNT = LQPA_PATH_COUNT,
    parameter int RUN_LIMIT  = LQPA_RUN_LIMIT,
    localparam int PW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_upd,
    input  logic [PW-1:0] i_path,
    input  t_grade_req    i_req,
    input  t_cfg          i_cfg,
    output t_quality      o_quality
);

    localparam t_run RUN_HI = 5'(RUN_LIMIT);
    localparam t_run RUN_LO = -5'(RUN_LIMIT);

    t_run r_delay_run [PATH_COUNT];
    t_run r_rel_run   [PATH_COUNT];
    t_run r_grad_run  [PATH_COUNT];
    t_run r_loss_run  [PATH_COUNT];

    t_run n_delay_run, n_rel_run, n_grad_run, n_loss_run;
    logic w_rise, w_bad, w_good;
    logic signed [16:0] w_rel_bad, w_rel_good, w_rise_lim;

    // A bad sample pushes the count up, a good one down, anything between clears it.
    function automatic t_run run_next(input t_run run, input logic is_bad,
                                      input logic is_good);
        t_run res;
        res = run;
        if (is_bad) begin
            if (run < 5'sd0) begin
                res = 5'sd1;
            end else if (run < RUN_SAT) begin
                res = run + 5'sd1;
            end
        end else if (is_good) begin
            if (run > 5'sd0) begin
                res = -5'sd1;
            end else if (run > RUN_SAT_NEG) begin
                res = run - 5'sd1;
            end
        end else begin
            res = 5'sd0;
        end
        return res;
    endfunction

    always_comb begin
        w_rel_bad  = $signed({1'b0, i_cfg.relative_bad_limit});
        w_rel_good = $signed({1'b0, i_cfg.relative_good_limit});
        w_rise_lim = $signed({1'b0, i_cfg.gradient_rise_limit});

        n_delay_run = run_next(r_delay_run[i_path],
                               i_req.rtt >= i_cfg.delay_bad_limit,
                               i_req.rtt <  i_cfg.delay_good_limit);
        n_rel_run   = run_next(r_rel_run[i_path],
                               i_req.rel >= w_rel_bad,
                               i_req.rel <  w_rel_good);
        n_grad_run  = run_next(r_grad_run[i_path],
                               i_req.grad > 17'sd0,
                               i_req.grad < 17'sd0);
        n_loss_run  = run_next(r_loss_run[i_path],
                               i_req.loss >= i_cfg.loss_bad_limit,
                               i_req.loss <  i_cfg.loss_good_limit);

        w_rise = (i_req.grad > w_rise_lim) && (i_req.last_grad > w_rise_lim) &&
                 (i_req.grad > i_req.last_grad);
        w_bad  = w_rise || (n_delay_run >= RUN_HI) || (n_rel_run >= RUN_HI) ||
                 (n_grad_run >= RUN_HI) || (n_loss_run >= RUN_HI);
        w_good = (n_delay_run <= RUN_LO) && (n_rel_run <= RUN_LO) &&
                 (n_loss_run <= RUN_LO);

        if (w_good) begin
            o_quality = Q_GOOD;
        end else if (w_bad) begin
            o_quality = Q_BAD;
        end else begin
            o_quality = Q_FLUCT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PATH_COUNT; p++) begin
                r_delay_run[p] <= '0;
                r_rel_run[p]   <= '0;
                r_grad_run[p]  <= '0;
                r_loss_run[p]  <= '0;
            end
        end else if (i_upd) begin
            r_delay_run[i_path] <= n_delay_run;
            r_rel_run[i_path]   <= n_rel_run;
            r_grad_run[i_path]  <= n_grad_run;
            r_loss_run[i_path]  <= n_loss_run;
        end
    end

endmodule

@@ rtl/link_quality_path_advisor_core.sv @@
// Top level of the link quality path advisor: sequencer, ring scan and result register.
// Steps per request: write, minimum scan once the ring is full, gradient reads with more than
// two entries left, calculation and grading; an ignored report goes straight to the result.
// One request is in work at a time; the next is taken in the cycle after the result is registered.
// The cost is set by the minimum scan, one RAM read and one compare per stored entry.
// Synchronous active-low reset clears the sequencer, ring pointers, run counters and registers.
module link_quality_path_advisor_core import lqpa_pkg::*; #(
    parameter int RING_DEPTH = LQPA_RING_DEPTH,
    parameter int RUN_LIMIT  = LQPA_RUN_LIMIT,
    parameter int PATH_COUNT = LQPA_PATH_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Probe report requests.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_probe     i_in_data,
    // Result requests.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_result    o_out_data,
    // Register writes.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Ring index width, path index width, and the RAM address built from both.
    localparam int IW = $clog2(RING_DEPTH);
    localparam int PW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
    localparam int AW = PW + IW;

    // Ring pointers advance and retreat modulo the ring depth.
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        return (x == IW'(RING_DEPTH - 1)) ? '0 : x + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
        return (x == '0) ? IW'(RING_DEPTH - 1) : x - IW'(1);
    endfunction

    t_state r_state, n_state;
    t_cfg   r_cfg;

    // Per-path ring pointers. A ring holds at most RING_DEPTH-1 entries.
    logic [IW-1:0] r_head_q [PATH_COUNT];
    logic [IW-1:0] r_tail_q [PATH_COUNT];

    // Working registers for the request in flight.
    logic [PW-1:0] r_path;
    logic          r_probe_bit;
    logic [15:0]   r_rtt;
    logic [6:0]    r_loss;
    logic [IW-1:0] r_tail;
    logic [IW-1:0] r_idx;
    logic          r_full;
    logic          r_use_grad;
    logic [15:0]   r_min;
    logic          r_min_first;
    logic          r_min_pend;
    logic [15:0]   r_last;
    logic [15:0]   r_llast;
    t_grade_req    r_req;
    t_result       r_res;
    logic          r_out_valid;
    t_result       r_out_data;

    // RAM and grading unit connections.
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [AW-1:0] w_ram_raddr;
    logic [15:0]   w_ram_rdata;
    logic          w_grade_upd;
    t_quality      w_quality;
    logic          w_out_load;
    logic          w_out_free;

    // Ring bookkeeping for the reporting path, used in the write step.
    logic [IW-1:0] w_head;
    logic [IW-1:0] w_tail;
    logic          w_full;
    logic [IW-1:0] w_head_new;
    logic [IW:0]   w_size;
    logic          w_use_grad;
    logic          w_reject;
    logic          w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // A report is dropped for an impossible loss figure, a path beyond the
    // configured count, or a path that is not currently in use.
    assign w_reject = (i_in_data.loss_percent > LOSS_MAX) ||
                      ({2'b00, i_in_data.probe_path} >= 3'(PATH_COUNT)) ||
                      !r_cfg.path_use_mask[i_in_data.probe_path];

    // When the ring is full the oldest entry is dropped after the minimum scan.
    // The gradients need more than two entries left after that drop.
    always_comb begin
        w_head     = r_head_q[r_path];
        w_tail     = r_tail_q[r_path];
        w_full     = (idx_inc(w_tail) == w_head);
        w_head_new = w_full ? idx_inc(w_head) : w_head;
        if (w_tail >= w_head_new) begin
            w_size = {1'b0, w_tail} - {1'b0, w_head_new};
        end else begin
            w_size = {1'b0, w_tail} + (IW + 1)'(RING_DEPTH) - {1'b0, w_head_new};
        end
        w_use_grad = (w_size > (IW + 1)'(2));
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_reject ? S_DONE : S_WRITE;
                end
            end
            S_WRITE: begin
                if (w_full) begin
                    n_state = S_MIN;
                end else begin
                    n_state = w_use_grad ? S_GRAD_A : S_CALC;
                end
            end
            S_MIN: begin
                if (idx_inc(r_idx) == r_tail) begin
                    n_state = S_MIN_END;
                end
            end
            S_MIN_END: n_state = r_use_grad ? S_GRAD_A : S_CALC;
            S_GRAD_A:  n_state = S_GRAD_B;
            S_GRAD_B:  n_state = S_GRAD_C;
            S_GRAD_C:  n_state = S_CALC;
            S_CALC:    n_state = S_EVAL;
            S_EVAL:    n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: RAM port control and unit strobes.
    always_comb begin
        o_in_ready  = 1'b0;
        w_ram_we    = 1'b0;
        w_grade_upd = 1'b0;
        w_out_load  = 1'b0;
        w_ram_waddr = {r_path, w_tail};
        w_ram_raddr = {r_path, r_idx};
        unique case (r_state)
            S_IDLE:   o_in_ready  = 1'b1;
            S_WRITE:  w_ram_we    = 1'b1;
            S_MIN:    w_ram_raddr = {r_path, r_idx};
            S_GRAD_A: w_ram_raddr = {r_path, idx_dec(r_tail)};
            S_GRAD_B: w_ram_raddr = {r_path, idx_dec(idx_dec(r_tail))};
            S_EVAL:   w_grade_upd = 1'b1;
            S_DONE:   w_out_load  = w_out_free;
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register file writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.path_use_mask       <= RST_PATH_MASK;
            r_cfg.delay_bad_limit     <= RST_DELAY_BAD;
            r_cfg.delay_good_limit    <= RST_DELAY_GOOD;
            r_cfg.relative_bad_limit  <= RST_REL_BAD;
            r_cfg.relative_good_limit <= RST_REL_GOOD;
            r_cfg.gradient_rise_limit <= RST_RISE;
            r_cfg.loss_bad_limit      <= RST_LOSS_BAD;
            r_cfg.loss_good_limit     <= RST_LOSS_GOOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATH_MASK:  r_cfg.path_use_mask       <= i_cfg_data[1:0];
                CFG_DELAY_BAD:  r_cfg.delay_bad_limit     <= i_cfg_data;
                CFG_DELAY_GOOD: r_cfg.delay_good_limit    <= i_cfg_data;
                CFG_REL_BAD:    r_cfg.relative_bad_limit  <= i_cfg_data;
                CFG_REL_GOOD:   r_cfg.relative_good_limit <= i_cfg_data;
                CFG_RISE:       r_cfg.gradient_rise_limit <= i_cfg_data;
                CFG_LOSS_BAD:   r_cfg.loss_bad_limit      <= i_cfg_data[6:0];
                CFG_LOSS_GOOD:  r_cfg.loss_good_limit     <= i_cfg_data[6:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Ring pointers move in the write step, once per report that is not dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PATH_COUNT; p++) begin
                r_head_q[p] <= '0;
                r_tail_q[p] <= '0;
            end
        end else if (r_state == S_WRITE) begin
            r_head_q[r_path] <= w_head_new;
            r_tail_q[r_path] <= idx_inc(w_tail);
        end
    end

    // Datapath of the request in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_path              <= PW'(i_in_data.probe_path);
            r_probe_bit         <= i_in_data.probe_path;
            r_rtt               <= i_in_data.rtt_ms;
            r_loss              <= i_in_data.loss_percent;
            // Rejected reports leave with this default untouched.
            r_res.ignored       <= 1'b1;
            r_res.quality       <= Q_FLUCT;
            r_res.advice_valid  <= 1'b0;
            r_res.advice        <= ADV_PATH_ONE;
        end

        if (r_state == S_WRITE) begin
            r_tail      <= w_tail;
            r_idx       <= w_head;
            r_full      <= w_full;
            r_use_grad  <= w_use_grad;
            r_min_first <= 1'b1;
        end else if (r_state == S_MIN) begin
            r_idx <= idx_inc(r_idx);
        end

        // The shared compare unit: each read returned during the scan is
        // weighed against the running minimum in the cycle after its address.
        r_min_pend <= (r_state == S_MIN);
        if (r_min_pend) begin
            r_min_first <= 1'b0;
            if (r_min_first || (w_ram_rdata < r_min)) begin
                r_min <= w_ram_rdata;
            end
        end

        if (r_state == S_GRAD_B) begin
            r_last <= w_ram_rdata;
        end
        if (r_state == S_GRAD_C) begin
            r_llast <= w_ram_rdata;
        end

        // Relative delay and both gradients, registered ahead of the grading step.
        if (r_state == S_CALC) begin
            r_req.rtt  <= r_rtt;
            r_req.loss <= r_loss;
            r_req.rel  <= r_full ? $signed({1'b0, r_rtt} - {1'b0, r_min}) : 17'sd0;
            if (r_use_grad) begin
                r_req.grad      <= $signed({1'b0, r_rtt} - {1'b0, r_last});
                r_req.last_grad <= $signed({1'b0, r_last} - {1'b0, r_llast});
            end else begin
                r_req.grad      <= 17'sd0;
                r_req.last_grad <= 17'sd0;
            end
        end

        // A bad grade asks for both paths unless both are already in use; a
        // good grade with both in use recommends the reporting path alone.
        if (r_state == S_EVAL) begin
            r_res.ignored <= 1'b0;
            r_res.quality <= w_quality;
            if ((w_quality == Q_BAD) && (r_cfg.path_use_mask != 2'b11)) begin
                r_res.advice_valid <= 1'b1;
                r_res.advice       <= ADV_BOTH;
            end else if ((w_quality == Q_GOOD) && (r_cfg.path_use_mask == 2'b11)) begin
                r_res.advice_valid <= 1'b1;
                r_res.advice       <= r_probe_bit ? ADV_PATH_TWO : ADV_PATH_ONE;
            end else begin
                r_res.advice_valid <= 1'b0;
                r_res.advice       <= ADV_PATH_ONE;
            end
        end

        if (w_out_load) begin
            r_out_data <= r_res;
        end
    end

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Delay rings of all paths share one RAM; the path number picks the region.
    lqpa_ram #(
        .WIDTH (16),
        .DEPTH (2 ** AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_rtt),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    lqpa_grade #(
        .PATH_COUNT (PATH_COUNT),
        .RUN_LIMIT  (RUN_LIMIT)
    ) u_grade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (w_grade_upd),
        .i_path    (r_path),
        .i_req     (r_req),
        .i_cfg     (r_cfg),
        .o_quality (w_quality)
    );

`ifndef NO_ASSERTIONS
    // The minimum scan never reaches the slot that holds the new report.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN) |-> (r_idx != r_tail))
        else $error("minimum scan reached the write slot");

    // A result is loaded only when the output register is free or being emptied.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a waiting result");

    // Counters are never updated while a new request could be taken.
    a_upd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grade_upd |-> !o_in_ready)
        else $error("run counters updated while idle");

    // An ignored result always carries the neutral grade and no advice.
    a_ignored_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.ignored) |->
            ((o_out_data.quality == Q_FLUCT) && !o_out_data.advice_valid))
        else $error("ignored result carries a grade or advice");
`endif

endmodule

@@ tb/sv/lqpa_advice_checker.sv @@
// Checker for the link quality path advisor: watches all three channels, grades each report, compares results.
`timescale 1ns / 1ps

module lqpa_advice_checker import lqpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_probe      i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);

    t_cfg        regs;
    logic [15:0] rtt_ring [LQPA_PATH_COUNT][LQPA_RING_DEPTH];
    int          ring_head [LQPA_PATH_COUNT];
    int          ring_tail [LQPA_PATH_COUNT];
    t_run        delay_run [LQPA_PATH_COUNT];
    t_run        rel_run   [LQPA_PATH_COUNT];
    t_run        grad_run  [LQPA_PATH_COUNT];
    t_run        loss_run  [LQPA_PATH_COUNT];
    t_result     pending_grades [$];
    int          mismatches = 0;

    task automatic report_mismatch(string what, logic [5:0] got, logic [5:0] want);
        $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_state();
        int p;
        int i;
        regs.path_use_mask       = RST_PATH_MASK;
        regs.delay_bad_limit     = RST_DELAY_BAD;
        regs.delay_good_limit    = RST_DELAY_GOOD;
        regs.relative_bad_limit  = RST_REL_BAD;
        regs.relative_good_limit = RST_REL_GOOD;
        regs.gradient_rise_limit = RST_RISE;
        regs.loss_bad_limit      = RST_LOSS_BAD;
        regs.loss_good_limit     = RST_LOSS_GOOD;
        for (p = 0; p < LQPA_PATH_COUNT; p++) begin
            for (i = 0; i < LQPA_RING_DEPTH; i++) begin
                rtt_ring[p][i] = '0;
            end
            ring_head[p] = 0;
            ring_tail[p] = 0;
            delay_run[p] = '0;
            rel_run[p]   = '0;
            grad_run[p]  = '0;
            loss_run[p]  = '0;
        end
        pending_grades.delete();
    endtask

    task automatic write_register(logic [3:0] index, logic [15:0] data);
        case (t_cfg_index'(index))
            CFG_PATH_MASK:  regs.path_use_mask       = data[1:0];
            CFG_DELAY_BAD:  regs.delay_bad_limit     = data;
            CFG_DELAY_GOOD: regs.delay_good_limit    = data;
            CFG_REL_BAD:    regs.relative_bad_limit  = data;
            CFG_REL_GOOD:   regs.relative_good_limit = data;
            CFG_RISE:       regs.gradient_rise_limit = data;
            CFG_LOSS_BAD:   regs.loss_bad_limit      = data[6:0];
            CFG_LOSS_GOOD:  regs.loss_good_limit     = data[6:0];
            default: ;
        endcase
    endtask

    // Hysteresis counter: a bad value flips a negative count to +1, a good one flips a
    // positive count to -1, anything in between clears it.
    function automatic t_run next_run(t_run run, int v, int bad_at, int good_below);
        int r;
        r = int'(run);
        if (v >= bad_at) begin
            if (r < 0) r = 1;
            else if (r < int'(RUN_SAT)) r = r + 1;
        end else if (v < good_below) begin
            if (r > 0) r = -1;
            else if (r > int'(RUN_SAT_NEG)) r = r - 1;
        end else begin
            r = 0;
        end
        return t_run'(r);
    endfunction

    function automatic t_result grade_report(t_probe pr);
        t_result res;
        int      p;
        int      rtt;
        int      loss;
        int      head;
        int      tail;
        int      size;
        int      rel;
        int      grad;
        int      last_grad;
        int      low;
        int      i;
        int      prev1;
        int      prev2;
        int      sign;
        logic    bad;
        logic    good;
        res.ignored      = 1'b1;
        res.quality      = Q_FLUCT;
        res.advice_valid = 1'b0;
        res.advice       = ADV_PATH_ONE;
        p    = int'(pr.probe_path);
        rtt  = int'(pr.rtt_ms);
        loss = int'(pr.loss_percent);
        if (loss > int'(LOSS_MAX) || p >= LQPA_PATH_COUNT || !regs.path_use_mask[p]) begin
            return res;
        end

        head = ring_head[p];
        tail = ring_tail[p];
        rtt_ring[p][tail] = pr.rtt_ms;
        rel = 0;
        // A full ring yields its minimum over the stored entries and drops the oldest.
        if ((tail + 1) % LQPA_RING_DEPTH == head) begin
            low = int'(rtt_ring[p][head]);
            for (i = head; i != tail; i = (i + 1) % LQPA_RING_DEPTH) begin
                if (int'(rtt_ring[p][i]) < low) low = int'(rtt_ring[p][i]);
            end
            head = (head + 1) % LQPA_RING_DEPTH;
            rel  = rtt - low;
        end
        size      = (tail + LQPA_RING_DEPTH - head) % LQPA_RING_DEPTH;
        grad      = 0;
        last_grad = 0;
        if (size > 2) begin
            prev1     = int'(rtt_ring[p][(tail + LQPA_RING_DEPTH - 1) % LQPA_RING_DEPTH]);
            prev2     = int'(rtt_ring[p][(tail + LQPA_RING_DEPTH - 2) % LQPA_RING_DEPTH]);
            grad      = rtt - prev1;
            last_grad = prev1 - prev2;
        end
        ring_head[p] = head;
        ring_tail[p] = (tail + 1) % LQPA_RING_DEPTH;

        sign = (grad > 0) ? 1 : ((grad < 0) ? -1 : 0);
        delay_run[p] = next_run(delay_run[p], rtt, int'(regs.delay_bad_limit),
                                int'(regs.delay_good_limit));
        rel_run[p]   = next_run(rel_run[p], rel, int'(regs.relative_bad_limit),
                                int'(regs.relative_good_limit));
        grad_run[p]  = next_run(grad_run[p], sign, 1, 0);
        loss_run[p]  = next_run(loss_run[p], loss, int'(regs.loss_bad_limit),
                                int'(regs.loss_good_limit));

        bad = (grad > int'(regs.gradient_rise_limit)) &&
              (last_grad > int'(regs.gradient_rise_limit)) && (grad > last_grad);
        if (int'(delay_run[p]) >= LQPA_RUN_LIMIT || int'(rel_run[p]) >= LQPA_RUN_LIMIT ||
            int'(grad_run[p]) >= LQPA_RUN_LIMIT || int'(loss_run[p]) >= LQPA_RUN_LIMIT) begin
            bad = 1'b1;
        end
        good = (int'(delay_run[p]) <= -LQPA_RUN_LIMIT) &&
               (int'(rel_run[p]) <= -LQPA_RUN_LIMIT) &&
               (int'(loss_run[p]) <= -LQPA_RUN_LIMIT);

        res.ignored = 1'b0;
        if (good) begin
            res.quality = Q_GOOD;
        end else if (bad) begin
            res.quality = Q_BAD;
        end else begin
            res.quality = Q_FLUCT;
        end
        if (res.quality == Q_BAD && !(&regs.path_use_mask)) begin
            res.advice_valid = 1'b1;
            res.advice       = ADV_BOTH;
        end else if (res.quality == Q_GOOD && (&regs.path_use_mask)) begin
            res.advice_valid = 1'b1;
            res.advice       = (p != 0) ? ADV_PATH_TWO : ADV_PATH_ONE;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            // Results are retired before a new report is graded in the same cycle.
            if (i_out_valid && i_out_ready) begin
                if (pending_grades.size() == 0) begin
                    report_mismatch("result with no report waiting", i_out_data, '0);
                end else begin
                    want = pending_grades.pop_front();
                    if (i_out_data.ignored !== want.ignored)
                        report_mismatch("ignored", 6'(i_out_data.ignored),
                                        6'(want.ignored));
                    if (i_out_data.quality !== want.quality)
                        report_mismatch("quality", 6'(i_out_data.quality),
                                        6'(want.quality));
                    if (i_out_data.advice_valid !== want.advice_valid)
                        report_mismatch("advice_valid", 6'(i_out_data.advice_valid),
                                        6'(want.advice_valid));
                    if (i_out_data.advice !== want.advice)
                        report_mismatch("advice", 6'(i_out_data.advice), 6'(want.advice));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_grades.push_back(grade_report(i_in_data));
            end
        end
        o_outstanding <= pending_grades.size();
        o_mismatches  <= mismatches;
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the link quality path advisor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import lqpa_pkg::*;

    // Generous bound on the whole run; a correct run needs well under a tenth of it.
    localparam int TIMEOUT_NS   = 4_000_000;
    // Cycles to let pass once nothing is expected, before a register write or the verdict.
    localparam int IDLE_PAD     = 4;
    localparam int DRAIN_CYCLES = 40;

    // Traffic shapes used to steer the run counters and gradients of one path.
    typedef enum int {
        K_CALM,
        K_CONGESTED,
        K_BETWEEN,
        K_RISING,
        K_NOISE
    } t_traffic;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_probe      in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic        in_ready;
    logic        out_valid;
    t_result     out_data;
    logic        cfg_ready;

    int          mismatch_total;
    int          outstanding;

    // Register settings as last written; the traffic shapes are placed around these limits.
    t_cfg        active_cfg;
    // Reports sent that the block should grade rather than flag.
    int          graded_reports = 0;
    // Idling controls: gaps between input requests and stalls on the result side.
    bit          gap_on   = 1'b1;
    bit          stall_on = 1'b1;
    bit          burst_calm;
    int          ramp_rtt;
    int          ramp_step;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    link_quality_path_advisor_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lqpa_advice_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatch_total),
        .o_outstanding (outstanding)
    );

    // Result-side ready: random stall bursts, broken by calm stretches with no stall.
    // Exactly one assignment to the ready per clock edge.
    initial begin : result_ready
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge clk);
            if (calm_left > 0) begin
                calm_left--;
            end else if (stall_left == 0 && stall_on) begin
                if ($urandom_range(0, 39) == 0) begin
                    calm_left = $urandom_range(20, 100);
                end else if ($urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [15:0] clamp_rtt(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // Raises the probe request and holds it until the block takes it. Valid is left high
    // so that a following request can go out in the very next cycle.
    task automatic send_probe(t_probe pr);
        in_valid <= 1'b1;
        in_data  <= pr;
        do @(posedge clk); while (!in_ready);
    endtask

    // One probe request followed, now and then, by an idle gap.
    task automatic offer(t_probe pr);
        send_probe(pr);
        if (active_cfg.path_use_mask[pr.probe_path] && pr.loss_percent <= LOSS_MAX) begin
            graded_reports++;
        end
        if (gap_on && !burst_calm && $urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic offer_fields(int path, int rtt, int loss);
        t_probe pr;
        pr.probe_path   = path[0];
        pr.rtt_ms       = clamp_rtt(rtt);
        pr.loss_percent = loss[6:0];
        offer(pr);
    endtask

    // Registers change only with the block idle: every result in, then a short pause.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all eight registers. The narrow ones carry random junk above their width,
    // which the block must drop.
    task automatic apply_settings(t_cfg s);
        logic [15:0] junk;
        wait_idle();
        junk = 16'($urandom);
        write_reg(CFG_DELAY_BAD, s.delay_bad_limit);
        write_reg(CFG_DELAY_GOOD, s.delay_good_limit);
        write_reg(CFG_REL_BAD, s.relative_bad_limit);
        write_reg(CFG_REL_GOOD, s.relative_good_limit);
        write_reg(CFG_RISE, s.gradient_rise_limit);
        write_reg(CFG_LOSS_BAD, {junk[8:0], s.loss_bad_limit});
        write_reg(CFG_LOSS_GOOD, {junk[15:7], s.loss_good_limit});
        write_reg(CFG_PATH_MASK, {junk[13:0], s.path_use_mask});
        cfg_valid <= 1'b0;
        active_cfg = s;
    endtask

    // Only the mask moves; path state must survive the change.
    task automatic change_mask(logic [1:0] mask);
        wait_idle();
        write_reg(CFG_PATH_MASK, {14'd0, mask});
        cfg_valid <= 1'b0;
        active_cfg.path_use_mask = mask;
    endtask

    function automatic t_cfg default_settings(logic [1:0] mask);
        t_cfg s;
        s.path_use_mask       = mask;
        s.delay_bad_limit     = RST_DELAY_BAD;
        s.delay_good_limit    = RST_DELAY_GOOD;
        s.relative_bad_limit  = RST_REL_BAD;
        s.relative_good_limit = RST_REL_GOOD;
        s.gradient_rise_limit = RST_RISE;
        s.loss_bad_limit      = RST_LOSS_BAD;
        s.loss_good_limit     = RST_LOSS_GOOD;
        return s;
    endfunction

    // Moderate limits keep the traffic shapes meaningful; wide ones may even invert the
    // good and bad limits.
    function automatic t_cfg random_settings(logic [1:0] mask, bit wide);
        t_cfg s;
        s.path_use_mask = mask;
        if (wide) begin
            s.delay_bad_limit     = 16'($urandom_range(0, 65535));
            s.delay_good_limit    = 16'($urandom_range(0, 65535));
            s.relative_bad_limit  = 16'($urandom_range(0, 65535));
            s.relative_good_limit = 16'($urandom_range(0, 65535));
            s.gradient_rise_limit = 16'($urandom_range(0, 65535));
            s.loss_bad_limit      = 7'($urandom_range(0, 100));
            s.loss_good_limit     = 7'($urandom_range(0, 100));
        end else begin
            s.delay_good_limit    = 16'($urandom_range(0, 200));
            s.delay_bad_limit     = 16'(s.delay_good_limit + $urandom_range(0, 200));
            s.relative_good_limit = 16'($urandom_range(0, 30));
            s.relative_bad_limit  = 16'(s.relative_good_limit + $urandom_range(0, 30));
            s.gradient_rise_limit = 16'($urandom_range(0, 40));
            s.loss_good_limit     = 7'($urandom_range(0, 20));
            s.loss_bad_limit      = 7'(s.loss_good_limit + $urandom_range(0, 20));
        end
        return s;
    endfunction

    // Mostly reports for paths in use, now and then one for a path that is switched off.
    function automatic int pick_path();
        case (active_cfg.path_use_mask)
            2'b01:   return ($urandom_range(0, 9) == 0) ? 1 : 0;
            2'b10:   return ($urandom_range(0, 9) == 0) ? 0 : 1;
            default: return $urandom_range(0, 1);
        endcase
    endfunction

    function automatic t_probe build_probe(t_traffic kind, int path);
        t_probe pr;
        int     rtt;
        int     loss;
        case (kind)
            K_CALM: begin
                rtt  = int'(active_cfg.delay_good_limit) - int'($urandom_range(1, 30));
                loss = int'(active_cfg.loss_good_limit) - int'($urandom_range(1, 4));
            end
            K_CONGESTED: begin
                rtt  = int'(active_cfg.delay_bad_limit) + int'($urandom_range(0, 60));
                loss = int'(active_cfg.loss_bad_limit) + int'($urandom_range(0, 10));
            end
            K_BETWEEN: begin
                rtt  = int'(active_cfg.delay_good_limit) + int'($urandom_range(0, 100));
                loss = $urandom_range(0, 100);
            end
            K_RISING: begin
                // Each step climbs more than the last, so both gradients rise together.
                ramp_rtt  = ramp_rtt + ramp_step;
                ramp_step = ramp_step + int'($urandom_range(1, 8));
                rtt       = ramp_rtt;
                loss      = $urandom_range(0, 8);
            end
            default: begin
                rtt  = $urandom_range(0, 65535);
                loss = $urandom_range(0, 127);
            end
        endcase
        if (kind != K_NOISE) begin
            if (loss < 0) loss = 0;
            if (loss > int'(LOSS_MAX)) loss = int'(LOSS_MAX);
            // An occasional out-of-range loss breaks up an otherwise clean sequence.
            if ($urandom_range(0, 29) == 0) loss = $urandom_range(101, 127);
        end
        pr.probe_path   = path[0];
        pr.rtt_ms       = clamp_rtt(rtt);
        pr.loss_percent = loss[6:0];
        return pr;
    endfunction

    // Bursts of one shape on one path, at times long enough to drive the counters to saturation
    // and to wrap the ring, until the given number of graded reports has gone out.
    task automatic run_traffic(int target);
        int       goal;
        int       len;
        int       path;
        int       k;
        int       draw;
        t_traffic kind;
        goal = graded_reports + target;
        while (graded_reports < goal) begin
            path = pick_path();
            draw = $urandom_range(0, 9);
            if (draw < 3) kind = K_CALM;
            else if (draw < 5) kind = K_CONGESTED;
            else if (draw < 7) kind = K_BETWEEN;
            else if (draw < 9) kind = K_RISING;
            else kind = K_NOISE;
            len        = $urandom_range(1, 24);
            burst_calm = ($urandom_range(0, 3) == 0);
            ramp_rtt   = $urandom_range(0, 300);
            ramp_step  = int'(active_cfg.gradient_rise_limit) + 1;
            for (k = 0; k < len; k++) begin
                offer(build_probe(kind, path));
            end
        end
    endtask

    initial begin : stimulus
        t_cfg s;
        int   k;
        active_cfg = default_settings(RST_PATH_MASK);
        burst_calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Out of reset no path is in use, so both paths are flagged.
        offer_fields(0, 1000, 0);
        offer_fields(1, 0, 0);

        // Path one only: path two is flagged, loss just above the range is flagged,
        // loss at its top limit is still graded.
        apply_settings(default_settings(2'b01));
        offer_fields(1, 40, 0);
        offer_fields(0, 50, 101);
        offer_fields(0, 50, 127);
        offer_fields(0, 0, 0);
        offer_fields(0, 65535, 100);
        offer_fields(0, 65535, 100);
        offer_fields(0, 65535, 100);
        offer_fields(0, 65535, 100);

        // Both paths: path one keeps its counters across the mask change. Calm reports on
        // path two turn good and name that path; then a steep climb marks it bad.
        change_mask(2'b11);
        offer_fields(1, 10, 0);
        offer_fields(1, 10, 0);
        offer_fields(1, 10, 0);
        offer_fields(1, 10, 0);
        offer_fields(0, 0, 0);
        offer_fields(1, 30, 0);
        offer_fields(1, 60, 0);
        offer_fields(1, 100, 0);
        offer_fields(0, 65535, 0);
        offer_fields(1, 65535, 127);

        // Random part, one phase per setting. Reset limits with both paths first.
        apply_settings(default_settings(2'b11));
        run_traffic(160);

        // All limits at zero: every value counts as bad.
        s = '0;
        s.path_use_mask = 2'b11;
        apply_settings(s);
        run_traffic(60);

        // All limits at their tops: nearly every value counts as good.
        s.delay_bad_limit     = 16'hFFFF;
        s.delay_good_limit    = 16'hFFFF;
        s.relative_bad_limit  = 16'hFFFF;
        s.relative_good_limit = 16'hFFFF;
        s.gradient_rise_limit = 16'hFFFF;
        s.loss_bad_limit      = LOSS_MAX;
        s.loss_good_limit     = LOSS_MAX;
        apply_settings(s);
        run_traffic(60);

        // Single paths with moderate random limits, so bad grades advise both paths.
        apply_settings(random_settings(2'b01, 1'b0));
        run_traffic(50);
        change_mask(2'b10);
        run_traffic(50);

        // No path in use for a short while: everything is flagged and state is kept.
        change_mask(2'b00);
        for (k = 0; k < 12; k++) begin
            offer(build_probe(K_NOISE, $urandom_range(0, 1)));
        end

        // Wide random limits, both paths.
        apply_settings(random_settings(2'b11, 1'b1));
        run_traffic(80);

        // Last stretch runs back to back with no idling on either side.
        gap_on   = 1'b0;
        stall_on = 1'b0;
        apply_settings(random_settings(2'b11, 1'b0));
        run_traffic(90);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lqpa_pkg.sv
rtl/lqpa_ram.sv
rtl/lqpa_grade.sv
rtl/link_quality_path_advisor_core.sv
tb/sv/lqpa_advice_checker.sv
tb/sv/tb.sv
